### hdl/ambient_light_hysteresis_debounce_assert.svh
// assertion macros for the ambient light filter checker
// expects clk and rst_n in the scope of each use
`ifndef AMBIENT_LIGHT_HYSTERESIS_DEBOUNCE_ASSERT_SVH
`define AMBIENT_LIGHT_HYSTERESIS_DEBOUNCE_ASSERT_SVH

// condition holds in the same cycle
`define ALHD_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("alhd check failed");

// condition holds in the next cycle
`define ALHD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("alhd check failed");

`endif

### hdl/alhd_pkg.sv
// shared types and constants of the ambient light hysteresis filter
// no dependencies
package alhd_pkg;

    localparam int LUX_W      = 24;
    localparam int TS_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_W      = 60;
    localparam int DEN_W      = 37;

    localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LUX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIOS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HYST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED  = 3'd7;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic [LUX_W-1:0] max_lux;
        logic [15:0]      ambient;
        logic [15:0]      fast_h;
        logic [16:0]      intercept;
        logic [31:0]      ratios;
        logic [LUX_W-1:0] min_hyst;
        logic [31:0]      debounce;
        logic             weighted;
    } cfg_t;

    typedef struct packed {
        logic             func;
        logic [TS_W-1:0]  ts;
        logic [LUX_W-1:0] lux;
    } item_t;

endpackage

### hdl/ambient_light_hysteresis_debounce.sv
// top level of the ambient light hysteresis and debounce filter
// depends on alhd_pkg, alhd_front, alhd_fifo, alhd_core
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata ts,lux  tuser func
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata raw,fast,slow,stable  tuser first,ovf
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// per item the engine prunes stale ring entries, then walks the window entries of each average
// through the single ring read port with a multiply-accumulate per entry and walks the newest
// entries for debounce; an average ends in a divide if its weight total > 0 and numerator >= 0
// a two-entry queue takes new items while the engine works; results wait in an output register
// reset clears the ring pointers and all filter state; the ring contents need no clearing
module ambient_light_hysteresis_debounce #(
    parameter int RING_DEPTH    = 64,
    parameter int PREDICTION_MS = 100
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [55:0]                     s_axis_tdata,   // timestamp_ms[31:0], lux_sample[55:32]
    input  logic                            s_axis_tuser,   // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [95:0]                     m_axis_tdata,   // raw, fast, slow, stable lux
    output logic [1:0]                      m_axis_tuser,   // first_result, ring_overflow
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [alhd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alhd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import alhd_pkg::*;

    cfg_t  cfg;
    item_t q_item, q_head;
    logic  q_push, q_full, q_pop, q_empty;

    alhd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg           (cfg),
        .q_push        (q_push),
        .q_item        (q_item),
        .q_full        (q_full)
    );

    alhd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    alhd_core #(
        .RING_DEPTH    (RING_DEPTH),
        .PREDICTION_MS (PREDICTION_MS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### hdl/alhd_fifo.sv
// two-entry queue between the intake and the filter engine
// depends on alhd_pkg
module alhd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  alhd_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output alhd_pkg::item_t head
);
    import alhd_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/alhd_div.sv
// restoring divider for the weighted averages, one quotient bit a cycle
// saturates at the lux maximum; depends on alhd_pkg
module alhd_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [alhd_pkg::NUM_W-1:0] num,
    input  logic [alhd_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [alhd_pkg::LUX_W-1:0] quot
);
    import alhd_pkg::*;

    localparam int REM_W = DEN_W + LUX_W;
    localparam int CNT_W = $clog2(LUX_W + 1);

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] d_reg, d_next;
    logic [LUX_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] num_x;
    logic [REM_W-1:0] den_top;

    assign num_x   = REM_W'(num);
    assign den_top = {den, {LUX_W{1'b0}}};
    assign done    = done_reg;
    assign quot    = q_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (num_x >= den_top)
            begin
                q_next    = LUX_MAX;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = num_x;
                d_next    = den_top >> 1;
                q_next    = '0;
                cnt_next  = CNT_W'(LUX_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_reg >= d_reg)
            begin
                rem_next = rem_reg - d_reg;
                q_next   = {q_reg[LUX_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[LUX_W-2:0], 1'b0};
            end
            d_next   = d_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

endmodule

### hdl/alhd_front.sv
// intake: configuration registers, lux clamp and queue fill
// depends on alhd_pkg
module alhd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [55:0]                     s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [alhd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alhd_pkg::CFG_DATA_W-1:0] cfg_data,
    output alhd_pkg::cfg_t                  cfg,
    output logic                            q_push,
    output alhd_pkg::item_t                 q_item,
    input  logic                            q_full
);
    import alhd_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    logic [LUX_W-1:0] in_lux;

    assign cfg_ready     = 1'b1;
    assign cfg           = cfg_reg;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign in_lux        = s_axis_tdata[55:32];

    always_comb
    begin
        q_item.func = s_axis_tuser;
        q_item.ts   = s_axis_tdata[31:0];
        q_item.lux  = (in_lux > cfg_reg.max_lux) ? cfg_reg.max_lux : in_lux;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_LUX:   cfg_next.max_lux   = cfg_data[LUX_W-1:0];
                CFG_AMBIENT:   cfg_next.ambient   = cfg_data[15:0];
                CFG_FAST:      cfg_next.fast_h    = cfg_data[15:0];
                CFG_INTERCEPT: cfg_next.intercept = cfg_data[16:0];
                CFG_RATIOS:    cfg_next.ratios    = cfg_data;
                CFG_MIN_HYST:  cfg_next.min_hyst  = cfg_data[LUX_W-1:0];
                CFG_DEBOUNCE:  cfg_next.debounce  = cfg_data;
                CFG_WEIGHTED:  cfg_next.weighted  = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_lux   <= LUX_MAX;
            cfg_reg.ambient   <= 16'd10000;
            cfg_reg.fast_h    <= 16'd2000;
            cfg_reg.intercept <= 17'd10000;
            cfg_reg.ratios    <= 32'd26215219;
            cfg_reg.min_hyst  <= 24'd160;
            cfg_reg.debounce  <= 32'd262145000;
            cfg_reg.weighted  <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/alhd_core.sv
// filter engine: sample ring, pruning, weighted averages, hysteresis and result register
// depends on alhd_pkg and alhd_div
module alhd_core #(
    parameter int RING_DEPTH    = 64,
    parameter int PREDICTION_MS = 100
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alhd_pkg::cfg_t       cfg,
    input  logic                 q_empty,
    input  alhd_pkg::item_t      q_head,
    output logic                 q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [95:0]          m_axis_tdata,
    output logic [1:0]           m_axis_tuser
);
    import alhd_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(RING_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE, ST_PR_ADDR, ST_PR_CMP, ST_PUSH, ST_EV_RAW, ST_EV_RAW_W,
        ST_WL_INIT, ST_WL_RD, ST_WL_W, ST_WL_LO, ST_WL_HI, ST_WL_DIV,
        ST_WL_WAIT, ST_WL_NEXT, ST_HYST, ST_BAND_B, ST_BAND_D,
        ST_TR_RD, ST_TR_CMP, ST_TR_END, ST_EMIT
    } state_t;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] v);
        if (v >= DEPTH_X)
            return IDX_W'(v - DEPTH_X);
        return v[IDX_W-1:0];
    endfunction

    // ring storage, time above lux
    logic [TS_W+LUX_W-1:0] ring_mem [RING_DEPTH];
    logic [TS_W+LUX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic                  mem_we;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 init_reg, init_next;
    logic [TS_W-1:0]      last_sample_reg, last_sample_next;
    logic [TS_W-1:0]      last_eval_reg, last_eval_next;
    logic [LUX_W-1:0]     fast_reg, fast_next;
    logic [LUX_W-1:0]     slow_reg, slow_next;
    logic [LUX_W-1:0]     stable_reg, stable_next;
    logic                 ovf_reg, ovf_next;
    logic [TS_W-1:0]      now_reg, now_next;
    logic                 is_sample_reg, is_sample_next;
    logic [LUX_W-1:0]     cur_lux_reg, cur_lux_next;
    logic signed [33:0]   bound_reg, bound_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic signed [17:0]   end_reg, end_next;
    logic signed [37:0]   w_reg, w_next;
    logic [LUX_W-1:0]     lux_reg, lux_next;
    logic                 last_reg, last_next;
    logic signed [59:0]   sum_reg, sum_next;
    logic signed [35:0]   tot_reg, tot_next;
    logic                 pass_slow_reg, pass_slow_next;
    logic [LUX_W-1:0]     raw_reg, raw_next;
    logic [LUX_W-1:0]     avg_reg, avg_next;
    logic signed [29:0]   bt_reg, bt_next;
    logic signed [29:0]   dt_reg, dt_next;
    logic signed [29:0]   thr_reg, thr_next;
    logic                 dir_bright_reg, dir_bright_next;
    logic                 dark_ok_reg, dark_ok_next;
    logic [15:0]          deb_reg, deb_next;
    logic [TS_W-1:0]      earliest_reg, earliest_next;
    logic                 first_reg, first_next;
    logic                 out_valid_reg, out_valid_next;
    logic [95:0]          out_data_reg, out_data_next;
    logic [1:0]           out_user_reg, out_user_next;

    logic                 div_start, div_done;
    logic [LUX_W-1:0]     div_q;

    logic [TS_W-1:0]      rd_time;
    logic [LUX_W-1:0]     rd_lux;
    logic signed [33:0]   rd_time_s, now_s, t_sel, s_full;
    logic signed [17:0]   s_val, a_val;
    logic signed [19:0]   b_val;
    logic signed [37:0]   w_prod;
    logic [42:0]          p_lo;
    logic signed [43:0]   p_hi;
    logic signed [60:0]   num_val;
    logic [DEN_W-1:0]     den_val;
    logic [15:0]          ratio_sel;
    logic [39:0]          band_prod;
    logic [27:0]          band_val;
    logic signed [29:0]   stable30, band30, bt_val, dt_val;
    logic [LUX_W-1:0]     trig, dtrig;
    logic signed [29:0]   trig30, dtrig30, lux30;
    logic                 due;
    logic [15:0]          horizon;
    logic                 out_free;

    assign rd_time   = rd_data_reg[TS_W+LUX_W-1:LUX_W];
    assign rd_lux    = rd_data_reg[LUX_W-1:0];
    assign rd_time_s = $signed({2'b00, rd_time});
    assign now_s     = $signed({2'b00, now_reg});
    // the oldest sample of a window starts at the horizon edge
    assign t_sel     = (rd_time_s < bound_reg) ? bound_reg : rd_time_s;
    assign s_full    = t_sel - now_s;
    assign s_val     = $signed(s_full[17:0]);
    assign a_val     = end_reg - s_val;
    assign b_val     = $signed({{2{end_reg[17]}}, end_reg}) + $signed({{2{s_val[17]}}, s_val})
                       + $signed({2'b00, cfg.intercept, 1'b0});
    assign w_prod    = a_val * b_val;
    assign p_lo      = lux_reg * w_reg[18:0];
    assign p_hi      = $signed({1'b0, lux_reg}) * $signed(w_reg[37:19]);
    assign num_val   = $signed({sum_reg, 1'b0}) + $signed({{25{tot_reg[35]}}, tot_reg});
    assign den_val   = {tot_reg[35:0], 1'b0};

    assign ratio_sel = (state_reg == ST_BAND_B) ? cfg.ratios[15:0] : cfg.ratios[31:16];
    assign band_prod = stable_reg * ratio_sel;
    assign band_val  = (band_prod[39:12] > {4'b0, cfg.min_hyst}) ? band_prod[39:12]
                                                                 : {4'b0, cfg.min_hyst};
    assign stable30  = $signed({6'b0, stable_reg});
    assign band30    = $signed({2'b0, band_val});
    assign bt_val    = stable30 + band30;
    assign dt_val    = stable30 - band30;
    assign trig      = cfg.weighted ? fast_reg : raw_reg;
    assign dtrig     = cfg.weighted ? slow_reg : raw_reg;
    assign trig30    = $signed({6'b0, trig});
    assign dtrig30   = $signed({6'b0, dtrig});
    assign lux30     = $signed({6'b0, rd_lux});
    assign due       = ({1'b0, earliest_reg} + {17'b0, deb_reg}) <= {1'b0, now_reg};
    assign horizon   = pass_slow_reg ? cfg.ambient : cfg.fast_h;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign q_pop         = (state_reg == ST_IDLE) && !q_empty;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    alhd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_val[NUM_W-1:0]),
        .den   (den_val),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        init_next       = init_reg;
        last_sample_next = last_sample_reg;
        last_eval_next  = last_eval_reg;
        fast_next       = fast_reg;
        slow_next       = slow_reg;
        stable_next     = stable_reg;
        ovf_next        = ovf_reg;
        now_next        = now_reg;
        is_sample_next  = is_sample_reg;
        cur_lux_next    = cur_lux_reg;
        bound_next      = bound_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        w_next          = w_reg;
        lux_next        = lux_reg;
        last_next       = last_reg;
        sum_next        = sum_reg;
        tot_next        = tot_reg;
        pass_slow_next  = pass_slow_reg;
        raw_next        = raw_reg;
        avg_next        = avg_reg;
        bt_next         = bt_reg;
        dt_next         = dt_reg;
        thr_next        = thr_reg;
        dir_bright_next = dir_bright_reg;
        dark_ok_next    = dark_ok_reg;
        deb_next        = deb_reg;
        earliest_next   = earliest_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        rd_addr         = start_reg;
        wr_addr         = start_reg;
        mem_we          = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    now_next       = q_head.ts;
                    cur_lux_next   = q_head.lux;
                    is_sample_next = (q_head.func == FUNC_SAMPLE);
                    bound_next     = $signed({2'b00, q_head.ts}) - $signed({18'b0, cfg.ambient});
                    if (q_head.func == FUNC_SAMPLE)
                    begin
                        // stale samples are dropped once running
                        if (!(init_reg && q_head.ts <= last_sample_reg))
                        begin
                            last_sample_next = q_head.ts;
                            last_eval_next   = q_head.ts;
                            state_next       = ST_PR_ADDR;
                        end
                    end
                    else if (init_reg && count_reg != '0 && q_head.ts >= last_eval_reg)
                    begin
                        last_eval_next = q_head.ts;
                        state_next     = ST_PR_ADDR;
                    end
                end
            end
            ST_PR_ADDR:
            begin
                rd_addr = wrap({1'b0, start_reg} + (IDX_W + 1)'(1));
                if (count_reg > CNT_W'(1))
                    state_next = ST_PR_CMP;
                else
                    state_next = is_sample_reg ? ST_PUSH : ST_EV_RAW;
            end
            ST_PR_CMP:
            begin
                if (rd_time_s <= bound_reg)
                begin
                    start_next = wrap({1'b0, start_reg} + (IDX_W + 1)'(1));
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_PR_ADDR;
                end
                else
                begin
                    state_next = is_sample_reg ? ST_PUSH : ST_EV_RAW;
                end
            end
            ST_PUSH:
            begin
                mem_we = 1'b1;
                if (count_reg >= CNT_W'(RING_DEPTH))
                begin
                    // full ring: overwrite the oldest slot
                    wr_addr    = start_reg;
                    start_next = wrap({1'b0, start_reg} + (IDX_W + 1)'(1));
                    ovf_next   = 1'b1;
                end
                else
                begin
                    wr_addr    = wrap({1'b0, start_reg} + (IDX_W + 1)'(count_reg));
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_EV_RAW;
            end
            ST_EV_RAW:
            begin
                rd_addr    = wrap({1'b0, start_reg} + (IDX_W + 1)'(count_reg - CNT_W'(1)));
                state_next = ST_EV_RAW_W;
            end
            ST_EV_RAW_W:
            begin
                raw_next       = rd_lux;
                pass_slow_next = 1'b0;
                if (cfg.weighted)
                begin
                    state_next = ST_WL_INIT;
                end
                else
                begin
                    fast_next  = '0;
                    slow_next  = '0;
                    state_next = ST_HYST;
                end
            end
            ST_WL_INIT:
            begin
                bound_next = now_s - $signed({18'b0, horizon});
                idx_next   = IDX_W'(count_reg - CNT_W'(1));
                end_next   = 18'(PREDICTION_MS);
                sum_next   = '0;
                tot_next   = '0;
                state_next = ST_WL_RD;
            end
            ST_WL_RD:
            begin
                rd_addr    = wrap({1'b0, start_reg} + {1'b0, idx_reg});
                state_next = ST_WL_W;
            end
            ST_WL_W:
            begin
                w_next     = w_prod;
                end_next   = s_val;
                lux_next   = rd_lux;
                last_next  = (rd_time_s <= bound_reg) || (idx_reg == '0);
                state_next = ST_WL_LO;
            end
            ST_WL_LO:
            begin
                sum_next   = sum_reg + $signed({17'b0, p_lo});
                tot_next   = tot_reg + $signed(w_reg[35:0]);
                state_next = ST_WL_HI;
            end
            ST_WL_HI:
            begin
                sum_next = sum_reg + $signed({p_hi[40:0], 19'b0});
                if (last_reg)
                begin
                    state_next = ST_WL_DIV;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = ST_WL_RD;
                end
            end
            ST_WL_DIV:
            begin
                if (tot_reg[35] || tot_reg == '0)
                begin
                    avg_next   = raw_reg;
                    state_next = ST_WL_NEXT;
                end
                else if (num_val[60])
                begin
                    avg_next   = '0;
                    state_next = ST_WL_NEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_WL_WAIT;
                end
            end
            ST_WL_WAIT:
            begin
                if (div_done)
                begin
                    avg_next   = div_q;
                    state_next = ST_WL_NEXT;
                end
            end
            ST_WL_NEXT:
            begin
                if (pass_slow_reg)
                begin
                    slow_next  = avg_reg;
                    state_next = ST_HYST;
                end
                else
                begin
                    fast_next      = avg_reg;
                    pass_slow_next = 1'b1;
                    state_next     = ST_WL_INIT;
                end
            end
            ST_HYST:
            begin
                if (!init_reg)
                begin
                    init_next   = 1'b1;
                    stable_next = cfg.weighted ? fast_reg : raw_reg;
                    first_next  = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_BAND_B;
                end
            end
            ST_BAND_B:
            begin
                bt_next    = bt_val;
                state_next = ST_BAND_D;
            end
            ST_BAND_D:
            begin
                dt_next       = dt_val;
                dark_ok_next  = (dtrig30 <= dt_val) && (trig30 <= dt_val);
                idx_next      = IDX_W'(count_reg - CNT_W'(1));
                earliest_next = now_reg;
                if (trig30 >= bt_reg)
                begin
                    thr_next        = bt_reg;
                    dir_bright_next = 1'b1;
                    deb_next        = cfg.debounce[15:0];
                    state_next      = ST_TR_RD;
                end
                else if ((dtrig30 <= dt_val) && (trig30 <= dt_val))
                begin
                    thr_next        = dt_val;
                    dir_bright_next = 1'b0;
                    dark_ok_next    = 1'b0;
                    deb_next        = cfg.debounce[31:16];
                    state_next      = ST_TR_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TR_RD:
            begin
                rd_addr    = wrap({1'b0, start_reg} + {1'b0, idx_reg});
                state_next = ST_TR_CMP;
            end
            ST_TR_CMP:
            begin
                // walk the run of newest samples beyond the threshold
                if (dir_bright_reg ? (lux30 < thr_reg) : (lux30 > thr_reg))
                begin
                    state_next = ST_TR_END;
                end
                else
                begin
                    earliest_next = rd_time;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_TR_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_TR_RD;
                    end
                end
            end
            ST_TR_END:
            begin
                if (due)
                begin
                    stable_next = trig;
                    first_next  = 1'b0;
                    state_next  = ST_EMIT;
                end
                else if (dark_ok_reg)
                begin
                    thr_next        = dt_reg;
                    dir_bright_next = 1'b0;
                    dark_ok_next    = 1'b0;
                    deb_next        = cfg.debounce[31:16];
                    idx_next        = IDX_W'(count_reg - CNT_W'(1));
                    earliest_next   = now_reg;
                    state_next      = ST_TR_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {stable_reg, slow_reg, fast_reg, raw_reg};
                    out_user_next  = {ovf_reg, first_reg};
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            start_reg       <= '0;
            count_reg       <= '0;
            init_reg        <= 1'b0;
            last_sample_reg <= '0;
            last_eval_reg   <= '0;
            fast_reg        <= '0;
            slow_reg        <= '0;
            stable_reg      <= '0;
            ovf_reg         <= 1'b0;
            pass_slow_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            start_reg       <= start_next;
            count_reg       <= count_next;
            init_reg        <= init_next;
            last_sample_reg <= last_sample_next;
            last_eval_reg   <= last_eval_next;
            fast_reg        <= fast_next;
            slow_reg        <= slow_next;
            stable_reg      <= stable_next;
            ovf_reg         <= ovf_next;
            pass_slow_reg   <= pass_slow_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        is_sample_reg  <= is_sample_next;
        cur_lux_reg    <= cur_lux_next;
        bound_reg      <= bound_next;
        idx_reg        <= idx_next;
        end_reg        <= end_next;
        w_reg          <= w_next;
        lux_reg        <= lux_next;
        last_reg       <= last_next;
        sum_reg        <= sum_next;
        tot_reg        <= tot_next;
        raw_reg        <= raw_next;
        avg_reg        <= avg_next;
        bt_reg         <= bt_next;
        dt_reg         <= dt_next;
        thr_reg        <= thr_next;
        dir_bright_reg <= dir_bright_next;
        dark_ok_reg    <= dark_ok_next;
        deb_reg        <= deb_next;
        earliest_reg   <= earliest_next;
        first_reg      <= first_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_addr] <= {now_reg, cur_lux_reg};
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

endmodule

### hdl/alhd_checker.sv
// port-level checks of the ambient light filter, bound to the top level
// depends on ambient_light_hysteresis_debounce_assert.svh
`include "ambient_light_hysteresis_debounce_assert.svh"

module alhd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic seen_in_reg, seen_in_next;
    logic seen_first_reg, seen_first_next;
    logic out_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        seen_in_next    = seen_in_reg || (s_axis_tvalid && s_axis_tready);
        seen_first_next = seen_first_reg || (out_acc && m_axis_tuser[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg    <= 1'b0;
            seen_first_reg <= 1'b0;
        end
        else
        begin
            seen_in_reg    <= seen_in_next;
            seen_first_reg <= seen_first_next;
        end
    end

    `ALHD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `ALHD_ASSERT_NOW(a_out_after_in, m_axis_tvalid, seen_in_reg)
    `ALHD_ASSERT_NOW(a_first_once, out_acc && m_axis_tuser[0], !seen_first_reg)
    `ALHD_ASSERT_NOW(a_first_leads, out_acc && !m_axis_tuser[0], seen_first_reg)

endmodule

bind ambient_light_hysteresis_debounce alhd_checker u_alhd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### sim/ambient_light_hysteresis_debounce_tb.sv
// self-checking testbench for the ambient light hysteresis and debounce filter
// depends on alhd_pkg and ambient_light_hysteresis_debounce; predicts each reading in a scoreboard
module ambient_light_hysteresis_debounce_tb;
    import alhd_pkg::*;

    localparam int    DEPTH      = 64;
    localparam longint LOOKAHEAD = 100;
    localparam int    SETTLE     = 3000;
    localparam int    NUM_ITEMS  = 1900;

    typedef struct {
        logic [LUX_W-1:0] raw;
        logic [LUX_W-1:0] fast;
        logic [LUX_W-1:0] slow;
        logic [LUX_W-1:0] stable;
        logic             first;
        logic             ovf;
    } reading_t;

    class lux_scoreboard;
        longint   lux_r[DEPTH];
        longint   time_r[DEPTH];
        int       start;
        int       count;
        bit       init_done;
        bit       ovf_seen;
        longint   last_sample;
        longint   last_eval;
        longint   fast_avg;
        longint   slow_avg;
        longint   stable;
        longint   regs[8];
        reading_t pending[$];
        int       errors;
        int       checked;
        int       flagged_ovf;

        function new();
            regs[CFG_MAX_LUX]   = 24'hFFFFFF;
            regs[CFG_AMBIENT]   = 10000;
            regs[CFG_FAST]      = 2000;
            regs[CFG_INTERCEPT] = 10000;
            regs[CFG_RATIOS]    = 26215219;
            regs[CFG_MIN_HYST]  = 160;
            regs[CFG_DEBOUNCE]  = 262145000;
            regs[CFG_WEIGHTED]  = 1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MAX_LUX:   regs[idx] = longint'(val[23:0]);
                CFG_AMBIENT:   regs[idx] = longint'(val[15:0]);
                CFG_FAST:      regs[idx] = longint'(val[15:0]);
                CFG_INTERCEPT: regs[idx] = longint'(val[16:0]);
                CFG_MIN_HYST:  regs[idx] = longint'(val[23:0]);
                CFG_WEIGHTED:  regs[idx] = longint'(val[0]);
                default:       regs[idx] = longint'(val);
            endcase
        endfunction

        function longint lux_of(int i);
            return lux_r[(start + i) % DEPTH];
        endfunction

        function longint time_of(int i);
            return time_r[(start + i) % DEPTH];
        endfunction

        function void prune(longint min_t);
            while (count > 1 && time_of(1) <= min_t)
            begin
                start = (start + 1) % DEPTH;
                count--;
            end
        endfunction

        function void store(longint t, longint lux);
            int pos;
            if (count >= DEPTH)
            begin
                start = (start + 1) % DEPTH;
                count = DEPTH - 1;
                ovf_seen = 1;
            end
            pos = (start + count) % DEPTH;
            time_r[pos] = t;
            lux_r[pos] = lux;
            count++;
        endfunction

        function longint floor_div(longint num, longint den);
            if (num >= 0)
                return num / den;
            return -((-num + den - 1) / den);
        endfunction

        // time-weighted mean over the window, rounded half up
        function longint window_mean(longint now, longint span);
            longint hs, tail, two_i, sum, tot, avg, t, s, w;
            int     first_idx, i, idx;
            if (count == 0)
                return 0;
            hs = now - span;
            tail = LOOKAHEAD;
            two_i = 2 * regs[CFG_INTERCEPT];
            sum = 0;
            tot = 0;
            first_idx = 0;
            for (i = 0; i + 1 < count; i++)
            begin
                if (time_of(i + 1) <= hs)
                    first_idx = i + 1;
                else
                    break;
            end
            for (i = count; i > first_idx; i--)
            begin
                idx = i - 1;
                t = time_of(idx);
                if (idx == first_idx && t < hs)
                    t = hs;
                s = t - now;
                w = (tail - s) * (tail + s + two_i);
                sum += lux_of(idx) * w;
                tot += w;
                tail = s;
            end
            if (tot <= 0)
                return lux_of(count - 1);
            avg = floor_div(2 * sum + tot, 2 * tot);
            if (avg < 0)
                avg = 0;
            if (avg > 64'hFFFFFF)
                avg = 64'hFFFFFF;
            return avg;
        endfunction

        function longint band(longint ratio);
            longint r;
            r = (stable * ratio) >>> 12;
            return (r > regs[CFG_MIN_HYST]) ? r : regs[CFG_MIN_HYST];
        endfunction

        function bit run_long_enough(longint now, longint thr, bit up, longint hold);
            longint earliest, l;
            int     i;
            earliest = now;
            for (i = count - 1; i >= 0; i--)
            begin
                l = lux_of(i);
                if (up ? (l < thr) : (l > thr))
                    break;
                earliest = time_of(i);
            end
            return earliest + hold <= now;
        endfunction

        function void queue_reading(longint raw, bit first);
            reading_t r;
            r.raw = raw[23:0];
            r.fast = fast_avg[23:0];
            r.slow = slow_avg[23:0];
            r.stable = stable[23:0];
            r.first = first;
            r.ovf = ovf_seen;
            ovf_seen = 0;
            pending = {pending, r};
        endfunction

        function void evaluate(longint now);
            longint raw, bt, dt, trig, dtrig;
            bit     up, down;
            raw = lux_of(count - 1);
            if (regs[CFG_WEIGHTED] != 0)
            begin
                fast_avg = window_mean(now, regs[CFG_FAST]);
                slow_avg = window_mean(now, regs[CFG_AMBIENT]);
            end
            else
            begin
                fast_avg = 0;
                slow_avg = 0;
            end
            if (!init_done)
            begin
                init_done = 1;
                stable = (regs[CFG_WEIGHTED] != 0) ? fast_avg : raw;
                queue_reading(raw, 1);
                return;
            end
            bt = stable + band(regs[CFG_RATIOS] & 64'hFFFF);
            dt = stable - band(regs[CFG_RATIOS] >> 16);
            trig = (regs[CFG_WEIGHTED] != 0) ? fast_avg : raw;
            dtrig = (regs[CFG_WEIGHTED] != 0) ? slow_avg : raw;
            up = trig >= bt && run_long_enough(now, bt, 1, regs[CFG_DEBOUNCE] & 64'hFFFF);
            down = dtrig <= dt && trig <= dt &&
                   run_long_enough(now, dt, 0, regs[CFG_DEBOUNCE] >> 16);
            if (!up && !down)
                return;
            stable = trig;
            queue_reading(raw, 0);
        endfunction

        // returns 1 when the item changed the filter state
        function bit note_input(item_t it);
            longint ts, lux;
            ts = longint'(it.ts);
            lux = longint'(it.lux);
            if (it.func == FUNC_SAMPLE)
            begin
                if (init_done && ts <= last_sample)
                    return 0;
                if (lux > regs[CFG_MAX_LUX])
                    lux = regs[CFG_MAX_LUX];
                prune(ts - regs[CFG_AMBIENT]);
                store(ts, lux);
                last_sample = ts;
                last_eval = ts;
                evaluate(ts);
                return 1;
            end
            if (!init_done || count == 0 || ts < last_eval)
                return 0;
            last_eval = ts;
            prune(ts - regs[CFG_AMBIENT]);
            evaluate(ts);
            return 1;
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        endtask

        task check(reading_t r);
            reading_t e;
            if (pending.size() == 0)
            begin
                report("unexpected reading raw", r.raw, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (r.ovf)
                flagged_ovf++;
            if (r.raw !== e.raw)       report("raw_lux", r.raw, e.raw);
            if (r.fast !== e.fast)     report("fast_lux", r.fast, e.fast);
            if (r.slow !== e.slow)     report("slow_lux", r.slow, e.slow);
            if (r.stable !== e.stable) report("stable_lux", r.stable, e.stable);
            if (r.first !== e.first)   report("first_result", r.first, e.first);
            if (r.ovf !== e.ovf)       report("ring_overflow", r.ovf, e.ovf);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata;    // timestamp_ms[31:0], lux_sample[55:32]
    logic                  s_axis_tuser;    // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [95:0]           m_axis_tdata;    // raw, fast, slow, stable lux
    logic [1:0]            m_axis_tuser;    // first_result, ring_overflow
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lux_scoreboard sb;
    int     src_idle;
    int     sink_stall;
    int     hold_req;
    int     effective;
    int     sent;
    longint cur_ts;
    longint level;

    ambient_light_hysteresis_debounce dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #300_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // reading sink, with random stalls and the long hold-off on request
    initial
    begin
        reading_t r;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                r.raw = m_axis_tdata[23:0];
                r.fast = m_axis_tdata[47:24];
                r.slow = m_axis_tdata[71:48];
                r.stable = m_axis_tdata[95:72];
                r.first = m_axis_tuser[0];
                r.ovf = m_axis_tuser[1];
                sb.check(r);
            end
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_req--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall);
        end
    end

    // entered and left just after a falling edge; tvalid stays high between items unless an idle gap is drawn
    task automatic send_item(item_t it);
        if ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.lux, it.ts};
        s_axis_tuser <= it.func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (sb.note_input(it))
            effective++;
        sent++;
        @(negedge clk);
    endtask

    // sender pauses until every reading is back and the engine has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // cfg_valid stays high between back-to-back writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic write_all(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                             logic [31:0] v3, logic [31:0] v4, logic [31:0] v5,
                             logic [31:0] v6, logic [31:0] v7);
        drain();
        write_reg(CFG_MAX_LUX, v0);
        write_reg(CFG_AMBIENT, v1);
        write_reg(CFG_FAST, v2);
        write_reg(CFG_INTERCEPT, v3);
        write_reg(CFG_RATIOS, v4);
        write_reg(CFG_MIN_HYST, v5);
        write_reg(CFG_DEBOUNCE, v6);
        write_reg(CFG_WEIGHTED, v7);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_fields(logic func, longint ts, logic [LUX_W-1:0] lux);
        item_t it;
        it.func = func;
        it.ts = ts[31:0];
        it.lux = lux;
        send_item(it);
    endtask

    function automatic logic [LUX_W-1:0] pick_lux();
        longint l;
        if ($urandom_range(99) < 2)
            level = ($urandom_range(1)) ? $urandom_range(24'hFFFFFF) : $urandom_range(4000);
        if ($urandom_range(99) < 15)
            return $urandom_range(24'hFFFFFF);
        l = level + $urandom_range(64) - 32;
        if (l < 0)
            l = 0;
        if (l > 64'hFFFFFF)
            l = 64'hFFFFFF;
        return l[23:0];
    endfunction

    // mostly ordered samples and ticks, the rest stale or backward items
    task automatic random_items(int n);
        int target;
        int kind;
        target = sent + n;
        while (sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                cur_ts += ($urandom_range(99) < 95) ? $urandom_range(1, 400)
                                                    : $urandom_range(1, 20000);
                if (cur_ts > 64'hFFFFFFFF)
                    cur_ts = 64'hFFFFFFFF;
                send_fields(FUNC_SAMPLE, cur_ts, pick_lux());
            end
            else if (kind < 85)
            begin
                cur_ts += $urandom_range(0, 300);
                if (cur_ts > 64'hFFFFFFFF)
                    cur_ts = 64'hFFFFFFFF;
                send_fields(FUNC_TICK, cur_ts, $urandom_range(24'hFFFFFF));
            end
            else
                send_fields(kind < 93 ? FUNC_SAMPLE : FUNC_TICK,
                            $urandom_range(cur_ts[31:0]), $urandom_range(24'hFFFFFF));
        end
    endtask

    task automatic idle_sweep(int n);
        src_idle = 0;  sink_stall = 0;  random_items(n / 4);
        src_idle = 87; sink_stall = 0;  random_items(n / 4);
        src_idle = 0;  sink_stall = 87; random_items(n / 4);
        src_idle = 30; sink_stall = 30; random_items(n / 4);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_SAMPLE;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_LUX;
        cfg_data = '0;
        src_idle = 0;
        sink_stall = 0;
        hold_req = 0;
        effective = 0;
        sent = 0;
        cur_ts = 0;
        level = 1000;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: tick before the first sample, first reading, stale and backward items,
        // full-scale lux, pruning after a long gap, equal-time tick
        send_fields(FUNC_TICK, 500, 24'hFFFFFF);
        send_fields(FUNC_SAMPLE, 0, 24'h000000);
        send_fields(FUNC_SAMPLE, 0, 24'hFFFFFF);
        send_fields(FUNC_SAMPLE, 50, 24'hFFFFFF);
        send_fields(FUNC_TICK, 50, 24'h000000);
        send_fields(FUNC_TICK, 10, 24'h123456);
        send_fields(FUNC_SAMPLE, 6000, 24'hFFFFFF);
        send_fields(FUNC_TICK, 12000, 24'h000000);
        send_fields(FUNC_SAMPLE, 30000, 24'h000000);
        send_fields(FUNC_TICK, 40000, 24'h000000);
        send_fields(FUNC_SAMPLE, 40001, 24'h000001);
        send_fields(FUNC_SAMPLE, 40000, 24'h000002);
        cur_ts = 40001;
        idle_sweep(200);

        // every change qualifies; the sink holds off so the input side backs up
        write_all(32'hFFFFFF, 10000, 2000, 10000, 0, 0, 0, 0);
        hold_req = 5000;
        random_items(40);
        idle_sweep(200);

        write_all(1, 65535, 65535, 131071, 32'hFFFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF, 1);
        idle_sweep(200);
        write_all(32'hFFFFFF, 1, 1, 1, 32'h10001000, 0, 32'h00640064, 1);
        idle_sweep(240);
        write_all(32'h800000, 3000, 500, 3000, 32'h01000200, 16, 32'h00C8012C, 1);
        idle_sweep(280);
        write_all(32'h7FFFFF, 800, 1000, 200, 32'h00000000, 0, 32'h00000000, 1);
        idle_sweep(200);
        write_all($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 65535),
                  $urandom_range(1, 65535), $urandom_range(1, 131071), $urandom(),
                  $urandom_range(24'hFFFFFF), $urandom(), $urandom_range(1));
        idle_sweep(280);

        // back to reset values, then run time up to the top of the counter
        write_all(32'hFFFFFF, 10000, 2000, 10000, 26215219, 160, 262145000, 1);
        cur_ts = 64'hFFFF0000;
        idle_sweep(240);
        send_fields(FUNC_SAMPLE, 64'hFFFFFFFF, 24'h000000);
        send_fields(FUNC_TICK, 64'hFFFFFFFF, 24'hFFFFFF);

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (sb.pending.size() != 0)
            sb.report("readings left over", sb.pending.size(), 0);
        $display("covered %0d items (%0d acted on) over 8 register settings and 4 idle mixes",
                 sent, effective);
        $display("checked %0d readings, %0d with ring overflow flagged", sb.checked,
                 sb.flagged_ovf);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/alhd_pkg.sv
hdl/alhd_fifo.sv
hdl/alhd_div.sv
hdl/alhd_front.sv
hdl/alhd_core.sv
hdl/ambient_light_hysteresis_debounce.sv
hdl/alhd_checker.sv
sim/ambient_light_hysteresis_debounce_tb.sv
